/* hw/rtl/bmorph_pkg.sv */
// ----------------------------------------------------------------------------
// bmorph_pkg
// Shared types and constants of the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmorph_pkg;

  localparam int PIXEL_W       = 8;
  localparam int LINE_LENGTH_W = 11;
  localparam int LINE_COUNT_W  = 16;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int ROW_W         = LINE_COUNT_W + 1;
  localparam int WIN_W         = 9;

  localparam int MAX_LINE_DEF    = 1024;
  localparam int LINE_LENGTH_RST = 512;
  localparam int LINE_COUNT_RST  = 512;
  localparam int LINE_MIN        = 3;

  localparam logic [PIXEL_W-1:0] FOREGROUND = 8'hFF;
  localparam logic [PIXEL_W-1:0] BACKGROUND = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH = 2'd0,
    REG_LINE_COUNT  = 2'd1,
    REG_OPERATION   = 2'd2
  } cfg_reg_e;

  typedef enum logic [OP_W-1:0] {
    OP_DILATE = 2'd0,
    OP_ERODE  = 2'd1,
    OP_OPEN   = 2'd2,
    OP_CLOSE  = 2'd3
  } op_e;

  typedef struct packed {
    logic en;
    logic restart;
    logic erode;
    logic pix;
  } stage_ctrl_t;

  typedef struct packed {
    logic in_frame;
    logic runnable;
    logic past_first;
    logic at_end;
    logic emitted;
    logic res;
  } stage_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/bmorph_stage.sv */
// ----------------------------------------------------------------------------
// bmorph_stage
// One 3x3 OR/AND window stage with a two-line store and raster position.
// ----------------------------------------------------------------------------
`default_nettype none

module bmorph_stage
  import bmorph_pkg::*;
#(
  parameter int MaxLine = MAX_LINE_DEF,
  localparam int ColW   = $clog2(MaxLine)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire stage_ctrl_t             ctrl_i,
  input  wire logic [ColW-1:0]         ncols_last_i,
  input  wire logic [LINE_COUNT_W-1:0] nlines_i,
  output      stage_stat_t             stat_o
);

  logic [1:0]       mem [MaxLine];
  logic [1:0]       rd_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [WIN_W-1:0] win_q, win_d;
  logic [WIN_W-1:0] padded;
  logic [ROW_W-1:0] nl_ext, nl_p1;
  logic             active, wr_en, wrap, emitted;
  logic [1:0]       old;
  logic [2:0]       v;

  assign nl_ext = {1'b0, nlines_i};
  assign nl_p1  = nl_ext + ROW_W'(1);
  assign active = row_q <= nl_ext;
  assign old    = (active && row_q != '0) ? rd_q : 2'b00;
  assign v      = active ? {old, ctrl_i.pix} : 3'b000;
  assign wr_en  = ctrl_i.en && !ctrl_i.restart && (row_q < nl_ext);
  assign wrap   = col_q == ncols_last_i;
  assign col_d  = wrap ? '0 : col_q + ColW'(1);
  assign row_d  = wrap ? row_q + ROW_W'(1) : row_q;

  always_comb begin
    if (col_q == '0) begin
      // previous line's last column is the center, right neighbor is zero
      padded  = {win_q[5:0], 3'b000};
      win_d   = {6'b0, v};
      emitted = row_q >= ROW_W'(2);
    end else begin
      win_d   = {win_q[5:0], v};
      padded  = win_d;
      emitted = row_q >= ROW_W'(1);
    end
  end

  assign stat_o.emitted    = emitted;
  assign stat_o.res        = ctrl_i.erode ? &padded : |padded;
  assign stat_o.in_frame   = row_q < nl_ext;
  assign stat_o.at_end     = (row_q == nl_p1) && (col_q == '0);
  assign stat_o.runnable   = active || stat_o.at_end;
  assign stat_o.past_first = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else if (ctrl_i.restart) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else if (ctrl_i.en) begin
      col_q <= col_d;
      row_q <= row_d;
      win_q <= win_d;
    end
  end

  // read ahead the next column so its data is registered when it arrives
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[col_q] <= {old[0], ctrl_i.pix};
    end
    if (ctrl_i.en) begin
      rd_q <= mem[col_d];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/binary_morphology_3x3.sv */
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// Streaming 3x3 binary dilation, erosion, opening and closing of a raster.
// ----------------------------------------------------------------------------
// a result is registered as the item that completes it is accepted
// throughput: one item per cycle while the result register is free or taken; one read-ahead port per line store
// first result on item line_length+2 (one stage) or 2*line_length+3 (two)
// reset clears positions, windows and output valid and loads the register
// defaults; line stores are not cleared, each is written before it is read
`default_nettype none

module binary_morphology_3x3
  import bmorph_pkg::*;
#(
  parameter int MaxLine = MAX_LINE_DEF,
  localparam int ColW   = $clog2(MaxLine)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [PIXEL_W-1:0]    s_axis_tdata,   // [7:0] pixel_in
  input  wire logic                  s_axis_tuser,   // [0] flush
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [PIXEL_W-1:0]    m_axis_tdata,   // [7:0] pixel_out
  output      logic                  m_axis_tlast,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LenW    = $clog2(MaxLine + 1);
  localparam int CmpW    = (LenW > LINE_LENGTH_W) ? LenW : LINE_LENGTH_W;
  localparam int LenRst  = (LINE_LENGTH_RST < MaxLine) ? LINE_LENGTH_RST : MaxLine;
  localparam logic [ColW-1:0] NcolsLastRst = ColW'(LenRst - 1);

  logic [ColW-1:0]         ncols_last_q;
  logic [LINE_COUNT_W-1:0] nlines_q;
  op_e                     op_q;
  logic                    out_valid_q;
  logic [PIXEL_W-1:0]      out_data_q;
  logic                    out_last_q;

  logic [CmpW-1:0]         len_ext, len_eff;
  logic [LINE_COUNT_W-1:0] cnt_eff;
  logic                    cfg_hit, acc, take, two, emit, last, restart, res;
  stage_ctrl_t             s1_ctrl, s2_ctrl;
  stage_stat_t             s1_stat, s2_stat;

  // configuration
  assign len_ext = CmpW'(cfg_data_i[LINE_LENGTH_W-1:0]);
  always_comb begin
    len_eff = len_ext;
    if (len_ext < CmpW'(LINE_MIN)) begin
      len_eff = CmpW'(LINE_MIN);
    end else if (len_ext > CmpW'(MaxLine)) begin
      len_eff = CmpW'(MaxLine);
    end
  end
  assign cnt_eff = (cfg_data_i[LINE_COUNT_W-1:0] < LINE_COUNT_W'(LINE_MIN)) ?
                   LINE_COUNT_W'(LINE_MIN) : cfg_data_i[LINE_COUNT_W-1:0];

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_LENGTH, REG_LINE_COUNT, REG_OPERATION: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncols_last_q <= NcolsLastRst;
      nlines_q     <= LINE_COUNT_W'(LINE_COUNT_RST);
      op_q         <= OP_DILATE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_LENGTH: ncols_last_q <= ColW'(len_eff - CmpW'(1));
        REG_LINE_COUNT:  nlines_q     <= cnt_eff;
        REG_OPERATION:   op_q         <= op_e'(cfg_data_i[OP_W-1:0]);
        default: ;
      endcase
    end
  end

  // item handling
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc  = s_axis_tvalid && s_axis_tready;
  // pixels only while the frame is incoming, flush items only after it
  assign take = acc && (s1_stat.in_frame != s_axis_tuser);
  assign two  = (op_q == OP_OPEN) || (op_q == OP_CLOSE);

  assign s1_ctrl.en      = take && s1_stat.runnable;
  assign s1_ctrl.restart = restart;
  assign s1_ctrl.erode   = (op_q == OP_ERODE) || (op_q == OP_OPEN);
  assign s1_ctrl.pix     = s1_stat.in_frame && (s_axis_tdata == FOREGROUND);

  assign s2_ctrl.en      = take && two && s1_stat.past_first;
  assign s2_ctrl.restart = restart;
  assign s2_ctrl.erode   = op_q == OP_CLOSE;
  assign s2_ctrl.pix     = s1_ctrl.en && s1_stat.emitted && s1_stat.res;

  assign emit    = two ? (s2_ctrl.en && s2_stat.emitted) : (s1_ctrl.en && s1_stat.emitted);
  assign res     = two ? s2_stat.res : s1_stat.res;
  assign last    = emit && (two ? s2_stat.at_end : s1_stat.at_end);
  assign restart = cfg_hit || last;

  bmorph_stage #(
    .MaxLine(MaxLine)
  ) u_stage1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (s1_ctrl),
    .ncols_last_i(ncols_last_q),
    .nlines_i    (nlines_q),
    .stat_o      (s1_stat)
  );

  bmorph_stage #(
    .MaxLine(MaxLine)
  ) u_stage2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (s2_ctrl),
    .ncols_last_i(ncols_last_q),
    .nlines_i    (nlines_q),
    .stat_o      (s2_stat)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= res ? FOREGROUND : BACKGROUND;
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten while waiting");

  a_binary_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == FOREGROUND || m_axis_tdata == BACKGROUND))
    else $error("result pixel not binary");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |=> (s1_stat.in_frame && !s1_stat.past_first && m_axis_tlast))
    else $error("frame did not restart after last item");

endmodule

`default_nettype wire
